/* rtl/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg - shared types and constants for the accelerometer step detector
// Request and result payload structs, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int AXIS_W         = 16;
    localparam int MAG_W          = AXIS_W;
    localparam int SQ_W           = 2 * AXIS_W;
    localparam int RING_DEPTH_DEF = 8;

    localparam logic [MAG_W-1:0] ONE_G_MAG = 16'd16390;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MARGIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd5;

    localparam logic [15:0] RISE_MARGIN_RST  = 16'd668;
    localparam logic [15:0] FALL_MARGIN_RST  = 16'd167;
    localparam logic [15:0] MIN_GAP_RST      = 16'd350;
    localparam logic [15:0] MAX_GAP_RST      = 16'd1500;
    localparam logic [7:0]  MIN_RUN_RST      = 8'd3;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd2500;

    typedef struct packed {
        logic                     mode;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [31:0]              time_ms;
        logic [31:0]              load_value;
    } asd_in_t;

    typedef struct packed {
        logic [31:0] step_total;
        logic        step_counted;
        logic [15:0] candidate_count;
        logic        in_peak;
    } asd_out_t;

endpackage

/* rtl/asd_mag.sv */
// ----------------------------------------------------------------------------
// asd_mag - bit-serial vector magnitude
// Squares the three axis magnitudes one multiplier bit per cycle, then takes
// the floor square root one result bit per cycle (restoring, radix 4 input).
// ----------------------------------------------------------------------------
module asd_mag
    import asd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    output logic                     done,
    output logic [MAG_W-1:0]         mag
);

    localparam int CNT_W = $clog2(AXIS_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AXIS_W - 1);

    typedef enum logic [1:0] {M_IDLE, M_SQR, M_ROOT} mstate_t;

    mstate_t              state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [AXIS_W-1:0]    abs_x_reg, abs_y_reg, abs_z_reg;
    logic [AXIS_W-1:0]    sh_x_reg, sh_y_reg, sh_z_reg;
    logic [SQ_W-1:0]      acc_reg;
    logic [MAG_W+2:0]     rem_reg;
    logic [MAG_W-1:0]     root_reg;

    logic [AXIS_W+1:0]    pp;
    logic [SQ_W-1:0]      acc_next;
    logic [MAG_W+2:0]     rem_sh;
    logic [MAG_W+2:0]     trial;
    logic                 root_fit;
    logic [AXIS_W-1:0]    abs_x, abs_y, abs_z;

    function automatic logic [AXIS_W-1:0] abs_val(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] u;
        u = v;
        return u[AXIS_W-1] ? (~u + {{(AXIS_W-1){1'b0}}, 1'b1}) : u;
    endfunction

    assign abs_x = abs_val(accel_x);
    assign abs_y = abs_val(accel_y);
    assign abs_z = abs_val(accel_z);

    // MSB-first shift-add: all three squares share one accumulator
    always_comb begin
        pp = (sh_x_reg[AXIS_W-1] ? {2'b00, abs_x_reg} : '0)
           + (sh_y_reg[AXIS_W-1] ? {2'b00, abs_y_reg} : '0)
           + (sh_z_reg[AXIS_W-1] ? {2'b00, abs_z_reg} : '0);
        acc_next = {acc_reg[SQ_W-2:0], 1'b0} + SQ_W'(pp);
        rem_sh   = {rem_reg[MAG_W:0], acc_reg[SQ_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        root_fit = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        abs_x_reg <= abs_x;
                        abs_y_reg <= abs_y;
                        abs_z_reg <= abs_z;
                        sh_x_reg  <= abs_x;
                        sh_y_reg  <= abs_y;
                        sh_z_reg  <= abs_z;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_SQR;
                    end
                end
                M_SQR: begin
                    acc_reg  <= acc_next;
                    sh_x_reg <= {sh_x_reg[AXIS_W-2:0], 1'b0};
                    sh_y_reg <= {sh_y_reg[AXIS_W-2:0], 1'b0};
                    sh_z_reg <= {sh_z_reg[AXIS_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= M_ROOT;
                    end
                end
                M_ROOT: begin
                    acc_reg <= {acc_reg[SQ_W-3:0], 2'b00};
                    if (root_fit) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[MAG_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[MAG_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign mag  = root_reg;

endmodule

/* rtl/accel_step_detector.sv */
// ----------------------------------------------------------------------------
// accel_step_detector - peak-detecting pedometer
// Magnitude of a 3-axis sample against a running ring mean, hysteresis peak
// detection, gap qualification and a saturating step total.
//
//   channel  dir  ports                      request
//   s_       in   s_valid/s_ready/s_data     sample or total load
//   m_       out  m_valid/m_ready/m_data     one result per input request
//   cfg_     in   cfg_we/cfg_index/cfg_wdata register write, no handshake
//
// A sample passes from acceptance to a valid result through the bit-serial
// squarer, the bit-serial square root, then ring update, mean compare, gap
// checks, commit and output load; a load request goes straight to output load.
// One request is in flight at a time; s_ready is high only when idle.
// A held result stalls only the commit into the output register.
// Reset is synchronous; the ring reads as one g until written (valid bits).
// ----------------------------------------------------------------------------
module accel_step_detector
    import asd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  asd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output asd_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int SUM_W = MAG_W + $clog2(RING_DEPTH);
    localparam int CMP_W = SUM_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_RST  = SUM_W'(RING_DEPTH * int'(ONE_G_MAG));
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAG, ST_SUM, ST_EVAL, ST_GAP, ST_COMMIT, ST_DONE
    } state_t;

    // configuration
    logic [15:0] rise_margin_reg, fall_margin_reg, min_gap_reg, max_gap_reg;
    logic [15:0] idle_timeout_reg;
    logic [7:0]  min_run_reg;

    // control and detector state
    state_t            state_reg;
    logic [IDX_W-1:0]  ring_idx_reg;
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              peak_reg;
    logic [31:0]       last_peak_reg;
    logic [15:0]       run_reg;
    logic [31:0]       total_reg;
    logic              counted_reg;
    logic              m_valid_reg;

    // per-request working registers
    logic [31:0]       now_reg;
    logic [31:0]       gap_reg;
    logic              rise_reg, fall_reg;
    logic              gap_ok_reg, long_reg, idle_reg, hit_reg;
    logic [15:0]       run_inc_reg;
    asd_out_t          m_data_reg;

    // ring memory
    logic [MAG_W-1:0]  ring_mem [RING_DEPTH];
    logic [MAG_W-1:0]  ring_rd_reg;
    logic              ring_rd_vld_reg;

    logic              mag_start, mag_done;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  old_mag;
    logic [CMP_W-1:0]  scaled;
    logic              rise_cmp, fall_cmp;
    logic [15:0]       run_inc;
    logic [7:0]        need;
    logic [31:0]       add;
    logic [32:0]       total_sum;

    assign s_ready   = (state_reg == ST_IDLE);
    assign mag_start = s_valid && s_ready && !s_data.mode;

    asd_mag u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mag_start),
        .accel_x (s_data.accel_x),
        .accel_y (s_data.accel_y),
        .accel_z (s_data.accel_z),
        .done    (mag_done),
        .mag     (mag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_margin_reg  <= RISE_MARGIN_RST;
            fall_margin_reg  <= FALL_MARGIN_RST;
            min_gap_reg      <= MIN_GAP_RST;
            max_gap_reg      <= MAX_GAP_RST;
            min_run_reg      <= MIN_RUN_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RISE_MARGIN:  rise_margin_reg  <= cfg_wdata;
                CFG_FALL_MARGIN:  fall_margin_reg  <= cfg_wdata;
                CFG_MIN_GAP_MS:   min_gap_reg      <= cfg_wdata;
                CFG_MAX_GAP_MS:   max_gap_reg      <= cfg_wdata;
                CFG_MIN_RUN:      min_run_reg      <= cfg_wdata[7:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ring: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            ring_mem[ring_idx_reg] <= mag;
        end
        ring_rd_reg <= ring_mem[ring_idx_reg];
    end

    always_comb begin
        old_mag   = ring_rd_vld_reg ? ring_rd_reg : ONE_G_MAG;
        // exact mean compares, scaled by the ring depth
        scaled    = CMP_W'(mag) * DEPTH_C;
        rise_cmp  = scaled > (CMP_W'(sum_reg) + CMP_W'(rise_margin_reg) * DEPTH_C);
        fall_cmp  = (scaled + CMP_W'(fall_margin_reg) * DEPTH_C) < CMP_W'(sum_reg);
        run_inc   = (run_reg == 16'hFFFF) ? run_reg : run_reg + 16'd1;
        need      = (min_run_reg == 8'd0) ? 8'd1 : min_run_reg;
        add       = (total_reg == 32'd0) ? {16'd0, run_inc_reg} : 32'd1;
        total_sum = {1'b0, total_reg} + {1'b0, add};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ring_idx_reg    <= '0;
            ring_vld_reg    <= '0;
            ring_rd_vld_reg <= 1'b0;
            sum_reg         <= SUM_RST;
            peak_reg        <= 1'b0;
            last_peak_reg   <= '0;
            run_reg         <= '0;
            total_reg       <= '0;
            counted_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            ring_rd_vld_reg <= ring_vld_reg[ring_idx_reg];
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        now_reg     <= s_data.time_ms;
                        counted_reg <= 1'b0;
                        if (s_data.mode) begin
                            total_reg <= s_data.load_value;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_MAG;
                        end
                    end
                end
                ST_MAG: begin
                    if (mag_done) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_reg <= sum_reg - SUM_W'(old_mag) + SUM_W'(mag);
                    ring_vld_reg[ring_idx_reg] <= 1'b1;
                    ring_idx_reg <= (ring_idx_reg == IDX_LAST) ? '0 : ring_idx_reg + 1'b1;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    rise_reg  <= !peak_reg && rise_cmp;
                    fall_reg  <= peak_reg && fall_cmp;
                    gap_reg   <= now_reg - last_peak_reg;
                    state_reg <= ST_GAP;
                end
                ST_GAP: begin
                    gap_ok_reg  <= (gap_reg >= {16'd0, min_gap_reg})
                                && (gap_reg <= {16'd0, max_gap_reg});
                    long_reg    <= gap_reg > {16'd0, max_gap_reg};
                    idle_reg    <= gap_reg > {16'd0, idle_timeout_reg};
                    run_inc_reg <= run_inc;
                    hit_reg     <= run_inc >= {8'd0, need};
                    state_reg   <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (rise_reg) begin
                        peak_reg      <= 1'b1;
                        last_peak_reg <= now_reg;
                        if (gap_ok_reg) begin
                            run_reg <= run_inc_reg;
                            if (hit_reg) begin
                                total_reg   <= total_sum[32] ? '1 : total_sum[31:0];
                                counted_reg <= (total_reg != '1);
                            end
                        end else if (long_reg) begin
                            run_reg <= 16'd1;
                        end
                    end else begin
                        // no rise: last peak unchanged, so the gap is the idle time
                        if (fall_reg) begin
                            peak_reg <= 1'b0;
                        end
                        if (idle_reg) begin
                            run_reg <= '0;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.step_total      <= total_reg;
                        m_data_reg.step_counted    <= counted_reg;
                        m_data_reg.candidate_count <= run_reg;
                        m_data_reg.in_peak         <= peak_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_mag_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_done |-> state_reg == ST_MAG)
        else $error("magnitude unit finished outside its wait state");

    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.step_counted) |-> m_data.step_total != '0)
        else $error("step counted with zero total");

    a_peak_time: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(peak_reg) |-> last_peak_reg == now_reg)
        else $error("peak entered without last-peak time update");
`endif

endmodule

/* tb/sv/accel_step_detector_tb.sv */
// ----------------------------------------------------------------------------
// accel_step_detector_tb - self-checking bench for the accelerometer pedometer
// Sends sample and total-load requests over the valid/ready input and keeps
// its own untimed copy of the magnitude ring, the hysteresis detector, the gap
// rules and the saturating counters. Every result is checked field by field
// in order. The sender runs in random bursts and the receiver stalls on its
// own pattern. Registers are reprogrammed between phases while the block is
// idle, including the extreme settings.
// ----------------------------------------------------------------------------
module accel_step_detector_tb;
    import asd_pkg::*;

    localparam int RING_D        = RING_DEPTH_DEF;
    localparam int ERR_PRINT_MAX = 40;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    asd_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    asd_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    accel_step_detector #(.RING_DEPTH(RING_D)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // pedometer state as the block should hold it
    logic [15:0] mag_ring [RING_D];
    int unsigned mag_sum;
    int unsigned ring_pos;
    logic        peak_on;
    logic [31:0] last_peak_ms;
    int unsigned run_len;
    logic [31:0] step_count;

    logic [15:0] rise_margin_q;
    logic [15:0] fall_margin_q;
    logic [15:0] min_gap_q;
    logic [15:0] max_gap_q;
    logic [7:0]  min_run_q;
    logic [15:0] idle_timeout_q;

    asd_out_t    due_results [$];
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned err_count     = 0;
    int unsigned burst_left    = 0;
    logic [31:0] walk_ms       = 32'd10000;

    function automatic void model_reset();
        for (int i = 0; i < RING_D; i++) begin
            mag_ring[i] = ONE_G_MAG;
        end
        mag_sum        = RING_D * ONE_G_MAG;
        ring_pos       = 0;
        peak_on        = 1'b0;
        last_peak_ms   = '0;
        run_len        = 0;
        step_count     = '0;
        rise_margin_q  = RISE_MARGIN_RST;
        fall_margin_q  = FALL_MARGIN_RST;
        min_gap_q      = MIN_GAP_RST;
        max_gap_q      = MAX_GAP_RST;
        min_run_q      = MIN_RUN_RST;
        idle_timeout_q = IDLE_TIMEOUT_RST;
    endfunction

    function automatic int unsigned axis_abs(input logic signed [15:0] v);
        int a;
        a = v;
        return (a < 0) ? -a : a;
    endfunction

    // floor square root of x^2 + y^2 + z^2, one result bit per pass
    function automatic int unsigned sample_magnitude(input asd_in_t req);
        longint unsigned energy;
        longint unsigned trial;
        int unsigned     root;
        int unsigned     ax;
        int unsigned     ay;
        int unsigned     az;
        ax     = axis_abs(req.accel_x);
        ay     = axis_abs(req.accel_y);
        az     = axis_abs(req.accel_z);
        energy = 64'(ax) * ax + 64'(ay) * ay + 64'(az) * az;
        root   = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= energy) begin
                root = int'(trial);
            end
        end
        return root;
    endfunction

    function automatic asd_out_t pedometer_step(input asd_in_t req);
        asd_out_t        res;
        int unsigned     mag;
        int unsigned     need;
        int unsigned     add;
        longint unsigned scaled;
        logic [31:0]     gap;
        logic [31:0]     since_peak;
        logic [31:0]     prev_total;
        res = '0;
        if (req.mode) begin
            step_count = req.load_value;
        end else begin
            mag                = sample_magnitude(req);
            mag_sum            = mag_sum - mag_ring[ring_pos] + mag;
            mag_ring[ring_pos] = mag[15:0];
            ring_pos           = (ring_pos + 1) % RING_D;
            // compare against the exact mean: both sides scaled by ring depth
            scaled = 64'(mag) * RING_D;
            if (!peak_on) begin
                if (scaled > 64'(mag_sum) + 64'(rise_margin_q) * RING_D) begin
                    gap     = req.time_ms - last_peak_ms;
                    peak_on = 1'b1;
                    if (gap >= min_gap_q && gap <= max_gap_q) begin
                        need = (min_run_q == 0) ? 1 : min_run_q;
                        if (run_len < 32'hFFFF) begin
                            run_len++;
                        end
                        if (run_len >= need) begin
                            prev_total = step_count;
                            // first steps after a zero total credit the whole run
                            add = (step_count == 0) ? run_len : 1;
                            if (64'(step_count) + add > 64'hFFFF_FFFF) begin
                                step_count = '1;
                            end else begin
                                step_count = step_count + add;
                            end
                            res.step_counted = (step_count != prev_total);
                        end
                    end else if (gap > max_gap_q) begin
                        run_len = 1;
                    end
                    last_peak_ms = req.time_ms;
                end
            end else if (scaled + 64'(fall_margin_q) * RING_D < 64'(mag_sum)) begin
                peak_on = 1'b0;
            end
            since_peak = req.time_ms - last_peak_ms;
            if (since_peak > idle_timeout_q && run_len > 0) begin
                run_len = 0;
            end
        end
        res.step_total      = step_count;
        res.candidate_count = run_len[15:0];
        res.in_peak         = peak_on;
        return res;
    endfunction

    function automatic asd_in_t make_sample(input int unsigned target, input logic [31:0] at_ms);
        asd_in_t req;
        int      xv;
        int      yv;
        int      zv;
        xv = int'($urandom_range(0, 3000)) - 1500;
        yv = int'($urandom_range(0, 3000)) - 1500;
        zv = int'(target);
        if ($urandom_range(0, 1) == 1) begin
            zv = -zv;
        end
        req.mode       = 1'b0;
        req.accel_x    = xv[15:0];
        req.accel_y    = yv[15:0];
        req.accel_z    = zv[15:0];
        req.time_ms    = at_ms;
        req.load_value = $urandom();
        return req;
    endfunction

    function automatic asd_in_t make_noise(input logic mode);
        asd_in_t req;
        req.mode       = mode;
        req.accel_x    = 16'($urandom());
        req.accel_y    = 16'($urandom());
        req.accel_z    = 16'($urandom());
        req.time_ms    = $urandom();
        req.load_value = $urandom();
        return req;
    endfunction

    function automatic asd_in_t make_load(input logic [31:0] total);
        asd_in_t req;
        req            = make_noise(1'b1);
        req.load_value = total;
        return req;
    endfunction

    function automatic logic [31:0] pick_load_value();
        case ($urandom_range(0, 3))
            0: begin
                return 32'hFFFF_FFFF - $urandom_range(0, 2);
            end
            1: begin
                return '0;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= ERR_PRINT_MAX) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // entered right after a rising edge; returns at the edge that took the request
    task automatic send_request(input asd_in_t req);
        int unsigned gap_cycles;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap_cycles != 0) begin
                s_valid <= 1'b0;
                repeat (gap_cycles) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        due_results = {due_results, pedometer_step(req)};
        requests_sent++;
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [15:0] rise, input logic [15:0] fall,
                                     input logic [15:0] gap_lo, input logic [15:0] gap_hi,
                                     input logic [7:0] run_need, input logic [15:0] idle_ms);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_RISE_MARGIN, CFG_FALL_MARGIN, CFG_MIN_GAP_MS,
                CFG_MAX_GAP_MS, CFG_MIN_RUN, CFG_IDLE_TIMEOUT};
        val = '{rise, fall, gap_lo, gap_hi, {8'h00, run_need}, idle_ms};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we         <= 1'b0;
        rise_margin_q  = rise;
        fall_margin_q  = fall;
        min_gap_q      = gap_lo;
        max_gap_q      = gap_hi;
        min_run_q      = run_need;
        idle_timeout_q = idle_ms;
    endtask

    // one clean peak followed by a deep dip that drops the detector out of peak phase
    task automatic step_pair(input logic [31:0] at_ms);
        send_request(make_sample(32000, at_ms));
        send_request(make_sample(8000, at_ms + 60));
    endtask

    // walking pattern: peak, dip, then up to four settle samples, peak to peak spacing mostly legal
    task automatic walk_steps(input int unsigned steps);
        logic [31:0] span;
        int unsigned parts;
        int unsigned hi;
        int unsigned pick;
        for (int s = 0; s < steps; s++) begin
            pick = $urandom_range(0, 9);
            hi   = (max_gap_q > min_gap_q + 2000) ? min_gap_q + 2000 : max_gap_q;
            if (min_gap_q > max_gap_q) begin
                span = $urandom_range(0, 3000);
            end else if (pick == 0 && min_gap_q > 0) begin
                span = $urandom_range(0, min_gap_q - 1);
            end else if (pick == 1) begin
                span = max_gap_q + 1 + $urandom_range(0, 4000);
            end else begin
                span = $urandom_range(min_gap_q, hi);
            end
            parts = $urandom_range(2, 6);
            send_request(make_sample($urandom_range(21000, 32767), walk_ms));
            for (int p = 1; p < parts; p++) begin
                send_request(make_sample((p == 1) ? $urandom_range(6000, 13000)
                                                  : $urandom_range(9000, 17500),
                                         walk_ms + span * p / parts));
            end
            walk_ms = walk_ms + span;
            if ($urandom_range(0, 29) == 0) begin
                send_request(make_load(pick_load_value()));
            end
        end
    endtask

    task automatic run_mixed_traffic(input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        start = requests_sent;
        while (requests_sent - start < quota) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                walk_steps($urandom_range(2, 10));
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 8)) send_request(make_noise(1'b0));
            end else begin
                send_request(make_load(pick_load_value()));
            end
        end
        finish_phase();
    endtask

    task automatic test_extreme_samples();
        asd_in_t req;
        req = make_noise(1'b0);
        req.accel_x = 16'sh8000; req.accel_y = 16'sh8000; req.accel_z = 16'sh8000;
        req.time_ms = '0;
        send_request(req);
        req.accel_x = 16'sh7FFF; req.accel_y = 16'sh7FFF; req.accel_z = 16'sh7FFF;
        req.time_ms = 32'd1;
        send_request(req);
        req.accel_x = '0; req.accel_y = '0; req.accel_z = '0;
        req.time_ms = 32'd2;
        send_request(req);
        req.accel_x = 16'sh8000; req.accel_y = '0; req.accel_z = 16'sh7FFF;
        req.time_ms = 32'hFFFF_FFFF;
        send_request(req);
        send_request(make_load(32'hFFFF_FFFF));
        send_request(make_load('0));
    endtask

    task automatic test_step_counting();
        // run builds to min_run, then the total jumps by the whole run
        step_pair(32'd1000);
        step_pair(32'd1500);
        step_pair(32'd2000);
        step_pair(32'd2500);
        // total pinned at its ceiling
        send_request(make_load(32'hFFFF_FFFE));
        step_pair(32'd3000);
        step_pair(32'd3500);
        // short gap, long gap restart, then idle clear on a quiet sample
        step_pair(32'd3600);
        step_pair(32'd6000);
        send_request(make_sample(16390, 32'd9000));
        finish_phase();
    endtask

    task automatic test_register_extremes();
        program_registers(16'd0, 16'd0, 16'd0, 16'hFFFF, 8'd0, 16'hFFFF);
        run_mixed_traffic(200);
        program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 8'd255, 16'd0);
        run_mixed_traffic(120);
        program_registers(RISE_MARGIN_RST, FALL_MARGIN_RST, 16'd1000, 16'd400,
                          MIN_RUN_RST, IDLE_TIMEOUT_RST);
        run_mixed_traffic(150);
    endtask

    task automatic test_random_walks();
        program_registers(16'd200, 16'd50, 16'd300, 16'd800, 8'd1, 16'd1000);
        run_mixed_traffic(400);
        program_registers(16'd2000, 16'd1000, 16'd100, 16'd3000, 8'd8, 16'd6000);
        run_mixed_traffic(400);
        // back to power-on values, with the millisecond clock about to wrap
        program_registers(RISE_MARGIN_RST, FALL_MARGIN_RST, MIN_GAP_RST, MAX_GAP_RST,
                          MIN_RUN_RST, IDLE_TIMEOUT_RST);
        walk_ms = 32'hFFFF_F000;
        run_mixed_traffic(530);
    endtask

    // receiver: switches between always-ready, coin-flip and mostly-stalled
    int unsigned stall_tick  = 0;
    int unsigned stall_style = 0;
    always @(posedge aclk) begin
        stall_tick++;
        if (stall_tick % 256 == 0) begin
            stall_style = $urandom_range(0, 2);
        end
        case (stall_style)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        asd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request pending, total=%0d",
                                          results_seen, m_data.step_total));
            end else begin
                want = due_results.pop_front();
                if (m_data.step_total !== want.step_total ||
                    m_data.step_counted !== want.step_counted ||
                    m_data.candidate_count !== want.candidate_count ||
                    m_data.in_peak !== want.in_peak) begin
                    report_mismatch($sformatf(
                        "result %0d total %0d/%0d counted %0b/%0b cand %0d/%0d peak %0b/%0b",
                        results_seen, m_data.step_total, want.step_total,
                        m_data.step_counted, want.step_counted,
                        m_data.candidate_count, want.candidate_count,
                        m_data.in_peak, want.in_peak));
                end
            end
        end
    end

    initial begin
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_samples();
        test_step_counting();
        test_register_extremes();
        test_random_walks();
        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(4 * 3_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
